### rtl/timeout_request_table_top_defines.svh
// Assertion macros used by the timeout request table RTL.
`ifndef TIMEOUT_REQUEST_TABLE_TOP_DEFINES_SVH
`define TIMEOUT_REQUEST_TABLE_TOP_DEFINES_SVH
`ifndef SYNTH
// Property holds at every clock edge outside reset.
`define TRT_ASSERT_ALWAYS(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("timeout_request_table: assertion failed");
// Antecedent implies consequent in the same cycle.
`define TRT_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("timeout_request_table: assertion failed");
// Antecedent implies consequent in the next cycle.
`define TRT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("timeout_request_table: assertion failed");
`else
`define TRT_ASSERT_ALWAYS(lbl, ck, rs, prop)
`define TRT_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define TRT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

### rtl/trt_pkg.sv
// Types and codes of the timeout request table.
package trt_pkg;

  // Request modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_CHECK  = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  // Incoming request
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] timer_id;
    logic [31:0] timeout_ms;
    logic [31:0] start_ms;
    logic [3:0]  slot_index;
  } req_t;

  // Result of one request
  typedef struct packed {
    logic        expired;
    logic [15:0] expired_id;
    logic [31:0] expired_timeout;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [31:0] time_now;
  } rsp_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] timeout;
    logic [31:0] start;
  } entry_t;

endpackage

### rtl/timeout_request_table_top.sv
// Timeout request table: millisecond counter plus an ordered table of delay requests.
// One request is taken at a time and gives exactly one result. Tick, insert, clear and
// unused modes go straight to the finish step. Delete at index i shifts the entries above
// it down by one. A check scans from entry 0 up to the first expired entry h, then shifts
// the entries above h down; a check that finds nothing scans the whole table. The pace is
// set by the single table memory: one entry read and one entry written per cycle, with a
// registered read port. The next request is taken while a result still waits on
// rsp_stall. The table memory needs no clearing pass after reset: only entries below
// the fill count are ever read.
`include "timeout_request_table_top_defines.svh"

module timeout_request_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  trt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output trt_pkg::rsp_t rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]      state;
  logic [CW-1:0]   count;
  logic [31:0]     ms_counter;
  logic [CW-1:0]   rd_ptr;
  logic [CW-1:0]   cmp_ptr;
  logic            rd_vld;
  trt_pkg::entry_t rd_data;
  trt_pkg::entry_t mem [TABLE_DEPTH];

  logic            res_expired;
  logic [15:0]     res_id;
  logic [31:0]     res_timeout;
  logic [1:0]      res_status;

  logic            accept;
  logic            issue;
  logic            hit;
  logic            scan_end;
  logic            ins_we;
  logic            shift_we;
  logic            bad_index;
  logic            timed_out;
  logic [AW-1:0]   dest_addr;
  logic            out_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Absolute elapsed time strictly beyond the timeout
  always_comb begin
    if (ms_counter >= rd_data.start) begin
      timed_out = (ms_counter - rd_data.start) > rd_data.timeout;
    end else begin
      timed_out = (rd_data.start - ms_counter) > rd_data.timeout;
    end
  end

  // Scan and shift control
  assign hit       = (state == S_SCAN) && rd_vld && timed_out;
  assign scan_end  = (state == S_SCAN) && rd_vld && !timed_out &&
                     ((cmp_ptr + CW'(1)) == count);
  assign issue     = (((state == S_SCAN) && !hit) || (state == S_SHIFT)) &&
                     (rd_ptr < count);
  assign shift_we  = (state == S_SHIFT) && rd_vld;
  assign dest_addr = AW'(cmp_ptr - CW'(1));
  assign ins_we    = accept && (req.mode == trt_pkg::MODE_INSERT) && (count < DEPTH_C);
  assign bad_index = IW'(req.slot_index) >= IW'(count);

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ins_we) begin
      mem[count[AW-1:0]] <= '{id: req.timer_id, timeout: req.timeout_ms,
                              start: req.start_ms};
    end else if (shift_we) begin
      mem[dest_addr] <= rd_data;
    end
    rd_data <= mem[rd_ptr[AW-1:0]];
    cmp_ptr <= rd_ptr;
  end

  // Sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ms_counter <= '0;
      rd_ptr     <= '0;
      rd_vld     <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_vld <= issue;
      // result goes out from the finish step, drops once taken
      if ((state == S_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.mode)
              trt_pkg::MODE_TICK: begin
                ms_counter <= ms_counter + 32'd1;
                state      <= S_FINISH;
              end
              trt_pkg::MODE_INSERT: begin
                if (count < DEPTH_C) begin
                  count <= count + CW'(1);
                end
                state <= S_FINISH;
              end
              trt_pkg::MODE_DELETE: begin
                if (!bad_index) begin
                  rd_ptr <= CW'(req.slot_index) + CW'(1);
                  state  <= S_SHIFT;
                end else begin
                  state <= S_FINISH;
                end
              end
              trt_pkg::MODE_CHECK: begin
                if (count != '0) begin
                  rd_ptr <= '0;
                  state  <= S_SCAN;
                end else begin
                  state <= S_FINISH;
                end
              end
              trt_pkg::MODE_CLEAR: begin
                count <= '0;
                state <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            rd_ptr <= cmp_ptr + CW'(1);
            state  <= S_SHIFT;
          end else if (scan_end) begin
            state <= S_FINISH;
          end else if (issue) begin
            rd_ptr <= rd_ptr + CW'(1);
          end
        end
        S_SHIFT: begin
          if (issue) begin
            rd_ptr <= rd_ptr + CW'(1);
          end else if (!rd_vld) begin
            count <= count - CW'(1);
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      res_expired <= 1'b0;
      res_id      <= '0;
      res_timeout <= '0;
      if ((req.mode == trt_pkg::MODE_INSERT) && (count >= DEPTH_C)) begin
        res_status <= trt_pkg::STATUS_FULL;
      end else if ((req.mode == trt_pkg::MODE_DELETE) && bad_index) begin
        res_status <= trt_pkg::STATUS_BAD_INDEX;
      end else begin
        res_status <= trt_pkg::STATUS_OK;
      end
    end
    if (hit) begin
      res_expired <= 1'b1;
      res_id      <= rd_data.id;
      res_timeout <= rd_data.timeout;
    end
    if ((state == S_FINISH) && out_free) begin
      rsp.expired         <= res_expired;
      rsp.expired_id      <= res_id;
      rsp.expired_timeout <= res_timeout;
      rsp.status          <= res_status;
      rsp.entry_count     <= 5'(count);
      rsp.time_now        <= ms_counter;
    end
  end

  // Checks
  `TRT_ASSERT_ALWAYS(a_count_range, clk, rst, count <= DEPTH_C)
  `TRT_ASSERT_IMPL(a_cmp_in_table, clk, rst, rd_vld, cmp_ptr < count)
  `TRT_ASSERT_IMPL(a_shift_dest, clk, rst, shift_we, cmp_ptr != '0)
  `TRT_ASSERT_NEXT(a_rsp_source, clk, rst, !rsp_valid && (state != S_FINISH), !rsp_valid)

endmodule

### dv/tb.sv
// Self-checking testbench for timeout_request_table_top: directed and random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int PHASE_ITEMS = 392;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;

  // Modes the block takes but does nothing with
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // One queued request with the pacing of its phase
  typedef struct {
    trt_pkg::req_t r;
    int unsigned   gap_pct;
    int unsigned   stall_pct;
    bit            drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  trt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  trt_pkg::rsp_t rsp;

  timeout_request_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  pending_t      req_queue[$];
  trt_pkg::rsp_t awaited_rsp[$];
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  int unsigned total_items = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned cycles = 0;
  bit          failed = 1'b0;

  // Shadow copy of the counter and the request table
  logic [31:0] clock_ms = '0;
  logic [4:0]  held_count = '0;
  logic [15:0] held_ids [TABLE_DEPTH];
  logic [31:0] held_timeouts [TABLE_DEPTH];
  logic [31:0] held_starts [TABLE_DEPTH];

  // Stimulus bookkeeping: phase pacing and the counter value seen so far
  int unsigned phase_gap = 0;
  int unsigned phase_stall = 0;
  bit          drain_next = 1'b0;
  logic [31:0] gen_now = '0;

  initial forever #2 clk = ~clk;

  // Remove one entry and close the hole
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_ids[i]      = held_ids[i + 1];
      held_timeouts[i] = held_timeouts[i + 1];
      held_starts[i]   = held_starts[i + 1];
    end
    held_count = held_count - 5'd1;
  endfunction

  // Apply one request to the shadow table and return its result
  function automatic trt_pkg::rsp_t table_step(trt_pkg::req_t r);
    trt_pkg::rsp_t o;
    logic [31:0]   elapsed;
    o = '0;
    o.status = trt_pkg::STATUS_OK;
    case (r.mode)
      trt_pkg::MODE_TICK: begin
        clock_ms = clock_ms + 32'd1;
      end
      trt_pkg::MODE_INSERT: begin
        if (held_count >= 5'(TABLE_DEPTH)) begin
          o.status = trt_pkg::STATUS_FULL;
        end else begin
          held_ids[held_count[3:0]]      = r.timer_id;
          held_timeouts[held_count[3:0]] = r.timeout_ms;
          held_starts[held_count[3:0]]   = r.start_ms;
          held_count = held_count + 5'd1;
        end
      end
      trt_pkg::MODE_DELETE: begin
        if ({1'b0, r.slot_index} >= held_count) begin
          o.status = trt_pkg::STATUS_BAD_INDEX;
        end else begin
          drop_entry(int'(r.slot_index));
        end
      end
      trt_pkg::MODE_CHECK: begin
        // first entry whose distance from now, either way, exceeds its timeout
        for (int i = 0; i < held_count; i++) begin
          elapsed = (clock_ms >= held_starts[i]) ? clock_ms - held_starts[i]
                                                 : held_starts[i] - clock_ms;
          if (elapsed > held_timeouts[i]) begin
            o.expired         = 1'b1;
            o.expired_id      = held_ids[i];
            o.expired_timeout = held_timeouts[i];
            drop_entry(i);
            break;
          end
        end
      end
      trt_pkg::MODE_CLEAR: begin
        held_count = '0;
      end
      default: begin
      end
    endcase
    o.entry_count = held_count;
    o.time_now    = clock_ms;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Compare one result against the oldest expectation
  function automatic void compare_rsp(trt_pkg::rsp_t got);
    trt_pkg::rsp_t want;
    if (awaited_rsp.size() == 0) begin
      $error("result with no request outstanding");
      failed = 1'b1;
      return;
    end
    want = awaited_rsp.pop_front();
    check_field("expired", 32'(want.expired), 32'(got.expired));
    check_field("expired_id", 32'(want.expired_id), 32'(got.expired_id));
    check_field("expired_timeout", want.expired_timeout, got.expired_timeout);
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    check_field("time_now", want.time_now, got.time_now);
  endfunction

  // Request of a given mode with noise in every other field
  function automatic trt_pkg::req_t noise_req(logic [2:0] mode);
    trt_pkg::req_t r;
    r.mode       = mode;
    r.timer_id   = 16'($urandom);
    r.timeout_ms = $urandom;
    r.start_ms   = $urandom;
    r.slot_index = 4'($urandom);
    return r;
  endfunction

  function automatic trt_pkg::req_t insert_req(logic [15:0] id, logic [31:0] tmo,
                                               logic [31:0] start);
    trt_pkg::req_t r;
    r = noise_req(trt_pkg::MODE_INSERT);
    r.timer_id   = id;
    r.timeout_ms = tmo;
    r.start_ms   = start;
    return r;
  endfunction

  function automatic trt_pkg::req_t delete_req(logic [3:0] idx);
    trt_pkg::req_t r;
    r = noise_req(trt_pkg::MODE_DELETE);
    r.slot_index = idx;
    return r;
  endfunction

  function automatic void queue_req(trt_pkg::req_t r);
    pending_t p;
    p.r         = r;
    p.gap_pct   = phase_gap;
    p.stall_pct = phase_stall;
    p.drain     = drain_next;
    drain_next  = 1'b0;
    req_queue.push_back(p);
    if (r.mode == trt_pkg::MODE_TICK) gen_now = gen_now + 32'd1;
  endfunction

  // Random mix, with inserts mostly close to the current time so checks hit
  task automatic random_phase(int unsigned gap, int unsigned stall, int n);
    int unsigned   pick;
    trt_pkg::req_t r;
    phase_gap   = gap;
    phase_stall = stall;
    drain_next  = 1'b1;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick == 0) begin
        // run the table into its full state
        repeat (TABLE_DEPTH + 1) queue_req(noise_req(trt_pkg::MODE_INSERT));
      end else if (pick < 30) begin
        queue_req(noise_req(trt_pkg::MODE_TICK));
      end else if (pick < 60) begin
        r = noise_req(trt_pkg::MODE_INSERT);
        if ($urandom_range(9) != 0) begin
          r.timeout_ms = $urandom_range(40);
          r.start_ms   = $urandom_range(1) ? gen_now + $urandom_range(40)
                                           : gen_now - $urandom_range(40);
        end
        queue_req(r);
      end else if (pick < 76) begin
        queue_req(noise_req(trt_pkg::MODE_CHECK));
      end else if (pick < 90) begin
        queue_req(delete_req(4'($urandom_range(9) < 7 ? $urandom_range(3)
                                                      : $urandom_range(15))));
      end else if (pick < 92) begin
        queue_req(noise_req(trt_pkg::MODE_CLEAR));
      end else if (pick < 95) begin
        queue_req(noise_req(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO))));
      end else begin
        queue_req(noise_req(trt_pkg::MODE_TICK));
      end
    end
  endtask

  // Driver: present queued requests, predict each one as it is taken
  always @(posedge clk) begin : drive_req
    pending_t nxt;
    bit       taken;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      taken = req_valid && !req_stall;
      if (taken) begin
        awaited_rsp.push_back(table_step(req));
        sent_count <= sent_count + 1;
      end
      if (!req_valid || taken) begin
        if (req_queue.size() != 0 &&
            !(req_queue[0].drain && (taken || sent_count != got_count)) &&
            $urandom_range(99) >= req_queue[0].gap_pct) begin
          nxt = req_queue.pop_front();
          req           <= nxt.r;
          req_valid     <= 1'b1;
          rsp_stall_pct <= nxt.stall_pct;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result taken, stall at the phase's rate
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        compare_rsp(rsp);
        got_count <= got_count + 1;
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("[timeout_request_table_top] ERROR");
      $finish;
    end
  end

  initial begin
    // Directed: elapsed-time edges, early and late starts, spare mode, full table
    queue_req(noise_req(trt_pkg::MODE_CHECK));
    queue_req(noise_req(trt_pkg::MODE_TICK));
    queue_req(insert_req(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_req(insert_req(16'h0000, 32'h0, gen_now));
    queue_req(insert_req(16'h1234, 32'h0, 32'h0));
    queue_req(insert_req(16'hABCD, 32'd5, gen_now + 32'd9));
    queue_req(noise_req(trt_pkg::MODE_CHECK));
    queue_req(noise_req(trt_pkg::MODE_CHECK));
    queue_req(noise_req(trt_pkg::MODE_CHECK));
    queue_req(noise_req(MODE_SPARE_HI));
    queue_req(delete_req(4'd2));
    repeat (TABLE_DEPTH - 2) queue_req(noise_req(trt_pkg::MODE_INSERT));
    queue_req(insert_req(16'h5A5A, 32'h0, 32'h0));
    queue_req(delete_req(4'd15));
    queue_req(delete_req(4'd0));
    queue_req(noise_req(trt_pkg::MODE_CLEAR));

    random_phase(0, 0, PHASE_ITEMS);
    random_phase(63, 0, PHASE_ITEMS);
    random_phase(0, 63, PHASE_ITEMS);
    random_phase(10, 10, PHASE_ITEMS);
    total_items = req_queue.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (got_count < total_items);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      $error("%0d results never arrived", awaited_rsp.size());
      failed = 1'b1;
    end

    if (!failed) begin
      $display("[timeout_request_table_top] OK");
    end else begin
      $display("[timeout_request_table_top] ERROR");
    end
    $finish;
  end

endmodule

### timeout_request_table_top.f
+incdir+rtl
rtl/trt_pkg.sv
rtl/timeout_request_table_top.sv
dv/tb.sv
